/* src/qtpbi_pkg.sv */
// Shared types, constants and codes of the quadtree point bucket index.
package qtpbi_pkg;

    // Defaults of the top level's parameters.
    localparam int TREE_DEPTH_DEF   = 2;
    localparam int BUCKET_SLOTS_DEF = 8;
    localparam int COORD_BITS_DEF   = 16;

    // Field widths of the channels.
    localparam int COORD_W    = 16;
    localparam int FUNC_W     = 1;
    localparam int LEAF_IDX_W = 4;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 4;
    localparam int CFG_IDX_W  = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [FUNC_W-1:0]         func_t;
    typedef logic [STATUS_W-1:0]       status_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    // Operation codes.
    localparam func_t FUNC_INSERT = 1'b0;
    localparam func_t FUNC_SEARCH = 1'b1;

    // Result status codes.
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_FULL = 2'd1;
    localparam status_t ST_MISS = 2'd2;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_LEFT_X   = 2'd0;
    localparam cfg_idx_t CFG_TOP_Y    = 2'd1;
    localparam cfg_idx_t CFG_RIGHT_X  = 2'd2;
    localparam cfg_idx_t CFG_BOTTOM_Y = 2'd3;

    // Region after reset.
    localparam coord_t RST_LEFT_X   = -16'sd200;
    localparam coord_t RST_TOP_Y    = 16'sd100;
    localparam coord_t RST_RIGHT_X  = 16'sd200;
    localparam coord_t RST_BOTTOM_Y = -16'sd100;

endpackage

/* src/qtpbi_if.sv */
// Handshake channel interfaces: request, response and configuration write.
interface qtpbi_req_if;
    import qtpbi_pkg::*;
    logic   valid;
    logic   ready;
    func_t  func;
    coord_t point_x;
    coord_t point_y;
    modport source(output valid, func, point_x, point_y, input ready);
    modport sink(input valid, func, point_x, point_y, output ready);
endinterface

interface qtpbi_rsp_if;
    import qtpbi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [LEAF_IDX_W-1:0] leaf_index;
    status_t               status;
    logic [FILL_W-1:0]     bucket_fill;
    modport source(output valid, leaf_index, status, bucket_fill, input ready);
    modport sink(input valid, leaf_index, status, bucket_fill, output ready);
endinterface

interface qtpbi_cfg_if;
    import qtpbi_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    coord_t   data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* src/quadtree_point_bucket_index.sv */
// Top level of the quadtree point bucket index: sequencer, region registers and stores.
//
// The block keeps a complete quadtree of TREE_DEPTH levels over the rectangle
// held in four configuration registers, and each of its 4**TREE_DEPTH leaves
// owns a bucket of up to BUCKET_SLOTS points. A request either inserts a point
// (appended, duplicates kept, dropped with a full status when the bucket is
// full) or searches for an exact match, and each request gives exactly one
// response with the leaf, the status and the leaf's fill. One request is in
// work at a time. The descent uses a single midpoint adder and comparator
// twice per level, once for x and once for y. The leaf's count is then read
// from the count RAM in S_CNT_RD and used in S_OP, where an insert writes the
// point and the new count. A search reads the bucket through the single read
// port of the point store, one slot per cycle with each slot compared in the
// cycle after its read is issued, and stops at a match or, on a miss, after
// the whole fill. The finished response sits in an output register, so the
// next request is taken while it waits for its transfer. The point store
// needs no clearing: only slots below a leaf's count are compared. The leaf
// counts sit in a small RAM with one valid flag per leaf, cleared at reset,
// so the block is ready right after reset.
module quadtree_point_bucket_index #(
    parameter int TREE_DEPTH   = qtpbi_pkg::TREE_DEPTH_DEF,
    parameter int BUCKET_SLOTS = qtpbi_pkg::BUCKET_SLOTS_DEF,
    parameter int COORD_BITS   = qtpbi_pkg::COORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    qtpbi_req_if.sink          req,
    qtpbi_rsp_if.source        rsp,
    qtpbi_cfg_if.sink          cfg
);
    import qtpbi_pkg::*;

    localparam int LEAF_BITS  = 2 * TREE_DEPTH;
    localparam int LEAF_COUNT = 1 << LEAF_BITS;
    localparam int LVL_BITS   = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(BUCKET_SLOTS + 1);
    localparam int STORE_DEP  = LEAF_COUNT * BUCKET_SLOTS;
    localparam int STORE_AW   = $clog2(STORE_DEP);
    localparam int KEY_BITS   = 2 * COORD_BITS;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DESC   = 3'd1;
    localparam logic [2:0] S_CNT_RD = 3'd2;
    localparam logic [2:0] S_OP     = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // Configuration registers.
    coord_t left_x_reg, top_y_reg, right_x_reg, bottom_y_reg;

    // Control state.
    logic [2:0]            state_reg, state_next;
    logic [LVL_BITS-1:0]   level_reg, level_next;
    logic                  phase_reg, phase_next;
    logic                  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LEAF_COUNT-1:0] cnt_valid_reg, cnt_valid_next;

    // Working payload.
    func_t                 func_reg, func_next;
    coord_t                px_reg, px_next, py_reg, py_next;
    coord_t                l_reg, l_next, r_reg, r_next;
    coord_t                t_reg, t_next, b_reg, b_next;
    logic                  right_reg, right_next;
    logic [LEAF_BITS-1:0]  leaf_reg, leaf_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]   idx_reg, idx_next;
    status_t               status_reg, status_next;
    logic [LEAF_IDX_W-1:0] out_leaf_reg, out_leaf_next;
    status_t               out_status_reg, out_status_next;
    logic [FILL_W-1:0]     out_fill_reg, out_fill_next;

    // Shared midpoint unit.
    coord_t mu_a, mu_b, mu_p, mu_mid;
    logic   mu_ge;

    // Store ports.
    logic                store_we;
    logic [STORE_AW-1:0] store_addr;
    logic [KEY_BITS-1:0] store_rdata;
    logic [KEY_BITS-1:0] key;
    logic                cnt_we;
    logic [CNT_BITS-1:0] cnt_wdata;
    logic [CNT_BITS-1:0] cnt_rdata;
    logic [CNT_BITS-1:0] cnt_now;
    logic [CNT_BITS-1:0] slot_sel;
    logic [31:0]         addr_wide;
    logic [31:0]         leaf_wide;
    logic [31:0]         fill_wide;

    qtpbi_mid_unit u_mid (
        .edge_a      (mu_a),
        .edge_b      (mu_b),
        .point       (mu_p),
        .mid         (mu_mid),
        .at_or_above (mu_ge)
    );

    // Points of all buckets, packed as x then y in COORD_BITS each.
    qtpbi_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (STORE_DEP)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_addr),
        .wdata (key),
        .raddr (store_addr),
        .rdata (store_rdata)
    );

    // Fill count of each leaf; a leaf whose valid flag is clear holds none.
    qtpbi_ram #(
        .WIDTH (CNT_BITS),
        .DEPTH (LEAF_COUNT)
    ) u_count (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (leaf_reg),
        .wdata (cnt_wdata),
        .raddr (leaf_reg),
        .rdata (cnt_rdata)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid       = out_valid_reg;
    assign rsp.leaf_index  = out_leaf_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.bucket_fill = out_fill_reg;

    // The key is sign extended or cut to COORD_BITS per coordinate.
    assign key     = {COORD_BITS'(px_reg), COORD_BITS'(py_reg)};
    assign cnt_now = cnt_valid_reg[leaf_reg] ? cnt_rdata : '0;

    // The scan reads at the running index; an insert writes at the fill.
    assign slot_sel   = (state_reg == S_SCAN) ? idx_reg : cnt_now;
    assign addr_wide  = 32'(leaf_reg) * 32'(BUCKET_SLOTS) + 32'(slot_sel);
    assign store_addr = addr_wide[STORE_AW-1:0];

    assign leaf_wide = 32'(leaf_reg);
    assign fill_wide = 32'(cnt_reg);

    // The midpoint unit works on x in the first phase of a level and on y in
    // the second.
    always_comb
    begin
        if (phase_reg == 1'b0)
        begin
            mu_a = l_reg;
            mu_b = r_reg;
            mu_p = px_reg;
        end
        else
        begin
            mu_a = t_reg;
            mu_b = b_reg;
            mu_p = py_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        phase_next      = phase_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        cnt_valid_next  = cnt_valid_reg;
        func_next       = func_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        t_next          = t_reg;
        b_next          = b_reg;
        right_next      = right_reg;
        leaf_next       = leaf_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        out_leaf_next   = out_leaf_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;
        store_we        = 1'b0;
        cnt_we          = 1'b0;
        cnt_wdata       = cnt_now + 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    px_next    = req.point_x;
                    py_next    = req.point_y;
                    l_next     = left_x_reg;
                    r_next     = right_x_reg;
                    t_next     = top_y_reg;
                    b_next     = bottom_y_reg;
                    level_next = '0;
                    phase_next = 1'b0;
                    state_next = S_DESC;
                end
            end

            S_DESC:
            begin
                if (phase_reg == 1'b0)
                begin
                    // At or above the x midpoint goes right.
                    right_next = mu_ge;
                    if (mu_ge)
                    begin
                        l_next = mu_mid;
                    end
                    else
                    begin
                        r_next = mu_mid;
                    end
                    phase_next = 1'b1;
                end
                else
                begin
                    // At or above the y midpoint goes up; quadrant bit one is "down".
                    if (mu_ge)
                    begin
                        b_next = mu_mid;
                    end
                    else
                    begin
                        t_next = mu_mid;
                    end
                    leaf_next  = LEAF_BITS'({leaf_reg, !mu_ge, right_reg});
                    phase_next = 1'b0;
                    if (level_reg == LVL_BITS'(TREE_DEPTH - 1))
                    begin
                        state_next = S_CNT_RD;
                    end
                    else
                    begin
                        level_next = level_reg + 1'b1;
                    end
                end
            end

            S_CNT_RD:
            begin
                // The count RAM reads at the leaf now held in leaf_reg.
                state_next = S_OP;
            end

            S_OP:
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    if (cnt_now < CNT_BITS'(BUCKET_SLOTS))
                    begin
                        store_we                 = 1'b1;
                        cnt_we                   = 1'b1;
                        cnt_valid_next[leaf_reg] = 1'b1;
                        cnt_next                 = cnt_now + 1'b1;
                        status_next              = ST_OK;
                    end
                    else
                    begin
                        cnt_next    = cnt_now;
                        status_next = ST_FULL;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_now;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // A read issued last cycle is compared while the next is issued.
                if (pend_reg && (store_rdata == key))
                begin
                    status_next = ST_OK;
                    pend_next   = 1'b0;
                    state_next  = S_DONE;
                end
                else if (idx_reg < cnt_reg)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    status_next = ST_MISS;
                    pend_next   = 1'b0;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_leaf_next   = leaf_wide[LEAF_IDX_W-1:0];
                    out_status_next = status_reg;
                    out_fill_next   = fill_wide[FILL_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            phase_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_valid_reg <= '0;
            left_x_reg    <= RST_LEFT_X;
            top_y_reg     <= RST_TOP_Y;
            right_x_reg   <= RST_RIGHT_X;
            bottom_y_reg  <= RST_BOTTOM_Y;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            cnt_valid_reg <= cnt_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_LEFT_X:   left_x_reg   <= cfg.data;
                    CFG_TOP_Y:    top_y_reg    <= cfg.data;
                    CFG_RIGHT_X:  right_x_reg  <= cfg.data;
                    CFG_BOTTOM_Y: bottom_y_reg <= cfg.data;
                    default:      left_x_reg   <= left_x_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        l_reg          <= l_next;
        r_reg          <= r_next;
        t_reg          <= t_next;
        b_reg          <= b_next;
        right_reg      <= right_next;
        leaf_reg       <= leaf_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        status_reg     <= status_next;
        out_leaf_reg   <= out_leaf_next;
        out_status_reg <= out_status_next;
        out_fill_reg   <= out_fill_next;
    end

endmodule

/* src/qtpbi_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module qtpbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/qtpbi_mid_unit.sv */
// Shared midpoint unit: floored midpoint of edge_a and edge_b and a compare against it.
module qtpbi_mid_unit (
    input  qtpbi_pkg::coord_t edge_a,
    input  qtpbi_pkg::coord_t edge_b,
    input  qtpbi_pkg::coord_t point,
    output qtpbi_pkg::coord_t mid,
    output logic              at_or_above
);
    import qtpbi_pkg::*;

    logic signed [COORD_W:0] sum;

    // The sum is one bit wider, so the arithmetic shift gives the exact floor.
    assign sum         = {edge_a[COORD_W-1], edge_a} + {edge_b[COORD_W-1], edge_b};
    assign mid         = sum[COORD_W:1];
    assign at_or_above = (point >= mid);

endmodule

/* src/qtpbi_checker.sv */
// Port-level checker of the quadtree point bucket index and its bind.
module qtpbi_checker #(
    parameter int BUCKET_SLOTS = qtpbi_pkg::BUCKET_SLOTS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input qtpbi_pkg::status_t               rsp_status,
    input logic [qtpbi_pkg::FILL_W-1:0]     rsp_bucket_fill
);
    import qtpbi_pkg::*;

    // One request at a time: a transfer closes the request channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response withdrawn before its transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL ||
                       rsp_status == ST_MISS))
        else $error("response status out of range");

    // A dropped insert is only reported for a bucket that is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status == ST_FULL) |->
            (32'(rsp_bucket_fill) == (32'(BUCKET_SLOTS) & 32'hF)))
        else $error("full status with a bucket that is not full");

endmodule

bind quadtree_point_bucket_index qtpbi_checker #(
    .BUCKET_SLOTS (BUCKET_SLOTS)
) u_qtpbi_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_bucket_fill (rsp.bucket_fill)
);
